@@ src/sfr_pkg.sv @@
// Shared types and constants of the sensor command packet framer.
package sfr_pkg;

  localparam logic [7:0] HEAD_HI     = 8'hEF;
  localparam logic [7:0] HEAD_LO     = 8'h01;
  localparam logic [7:0] CMD_FLAG    = 8'h01;
  localparam logic [7:0] MAX_PAYLOAD = 8'd255;
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 16;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] payload_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_end;
    logic       packet_end;
    logic       count_error;
  } out_word_t;

  // One classified input word, as handed from the front to the back.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic        count_error;
    logic [8:0]  length;
    logic [15:0] checksum;
  } cmd_t;

  typedef enum logic [3:0] {
    STEP_HEAD_HI,
    STEP_HEAD_LO,
    STEP_ADDR3,
    STEP_ADDR2,
    STEP_ADDR1,
    STEP_ADDR0,
    STEP_FLAG,
    STEP_LEN_HI,
    STEP_LEN_LO,
    STEP_PAYLOAD,
    STEP_SUM_HI,
    STEP_SUM_LO
  } step_t;

endpackage

@@ src/sfr_fifo.sv @@
// Small register-based first-in first-out queue.
module sfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("fifo count above depth");
`endif

endmodule

@@ src/sfr_front.sv @@
// Front end: accept input words, check the count, track the checksum.
module sfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  sfr_pkg::in_word_t in_data,
  output logic             in_full,
  input  logic             cmd_full,
  output logic             cmd_push,
  output sfr_pkg::cmd_t    cmd_data
);

  logic        in_packet_r, in_packet_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [7:0]  cnt_sat;
  logic [8:0]  length;
  logic [7:0]  rem;
  logic [15:0] sum_base, sum_new;
  logic        err, accept;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    cnt_sat  = (in_data.payload_count > sfr_pkg::MAX_PAYLOAD) ? sfr_pkg::MAX_PAYLOAD
                                                              : in_data.payload_count;
    length   = {1'b0, cnt_sat} + 9'd2;
    rem      = in_data.first_byte ? cnt_sat : bytes_remaining_r;
    sum_base = in_data.first_byte
             ? 16'(sfr_pkg::CMD_FLAG) + 16'(length[8]) + 16'(length[7:0])
             : running_sum_r;
    sum_new  = sum_base + 16'(in_data.payload_byte);
    err      = in_data.last_byte ? (rem != 8'd1) : (rem <= 8'd1);

    // Words outside a packet that do not open one are dropped.
    cmd_push              = accept && (in_data.first_byte || in_packet_r);
    cmd_data.payload_byte = in_data.payload_byte;
    cmd_data.first_byte   = in_data.first_byte;
    cmd_data.last_byte    = in_data.last_byte;
    cmd_data.count_error  = err;
    cmd_data.length       = length;
    cmd_data.checksum     = sum_new;

    in_packet_nxt       = in_packet_r;
    running_sum_nxt     = running_sum_r;
    bytes_remaining_nxt = bytes_remaining_r;
    if (cmd_push) begin
      if (in_data.last_byte) begin
        in_packet_nxt       = 1'b0;
        running_sum_nxt     = '0;
        bytes_remaining_nxt = '0;
      end else begin
        in_packet_nxt       = 1'b1;
        running_sum_nxt     = sum_new;
        bytes_remaining_nxt = (rem != 8'd0) ? rem - 8'd1 : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r       <= 1'b0;
      running_sum_r     <= '0;
      bytes_remaining_r <= '0;
    end else begin
      in_packet_r       <= in_packet_nxt;
      running_sum_r     <= running_sum_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> (running_sum_r == 16'd0 && bytes_remaining_r == 8'd0))
    else $error("idle framer holds stale packet state");
`endif

endmodule

@@ src/sfr_back.sv @@
// Back end: serialize one classified word into packet bytes.
module sfr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           device_address,
  input  logic                  cmd_empty,
  input  sfr_pkg::cmd_t         cmd_data,
  output logic                  cmd_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output sfr_pkg::out_word_t    out_data
);

  sfr_pkg::step_t step_r, step_nxt, cur_step, final_step;
  logic           started_r, started_nxt;
  logic           fire, done;

  always_comb begin
    if (started_r) begin
      cur_step = step_r;
    end else if (cmd_data.first_byte) begin
      cur_step = sfr_pkg::STEP_HEAD_HI;
    end else begin
      cur_step = sfr_pkg::STEP_PAYLOAD;
    end
    final_step = cmd_data.last_byte ? sfr_pkg::STEP_SUM_LO : sfr_pkg::STEP_PAYLOAD;
    fire       = !cmd_empty && !out_full;
    done       = (cur_step == final_step);

    case (cur_step)
      sfr_pkg::STEP_HEAD_HI: out_data.tx_byte = sfr_pkg::HEAD_HI;
      sfr_pkg::STEP_HEAD_LO: out_data.tx_byte = sfr_pkg::HEAD_LO;
      sfr_pkg::STEP_ADDR3:   out_data.tx_byte = device_address[31:24];
      sfr_pkg::STEP_ADDR2:   out_data.tx_byte = device_address[23:16];
      sfr_pkg::STEP_ADDR1:   out_data.tx_byte = device_address[15:8];
      sfr_pkg::STEP_ADDR0:   out_data.tx_byte = device_address[7:0];
      sfr_pkg::STEP_FLAG:    out_data.tx_byte = sfr_pkg::CMD_FLAG;
      sfr_pkg::STEP_LEN_HI:  out_data.tx_byte = {7'd0, cmd_data.length[8]};
      sfr_pkg::STEP_LEN_LO:  out_data.tx_byte = cmd_data.length[7:0];
      sfr_pkg::STEP_PAYLOAD: out_data.tx_byte = cmd_data.payload_byte;
      sfr_pkg::STEP_SUM_HI:  out_data.tx_byte = cmd_data.checksum[15:8];
      sfr_pkg::STEP_SUM_LO:  out_data.tx_byte = cmd_data.checksum[7:0];
      default:               out_data.tx_byte = cmd_data.payload_byte;
    endcase
    out_data.run_end     = done;
    out_data.packet_end  = (cur_step == sfr_pkg::STEP_SUM_LO);
    out_data.count_error = cmd_data.count_error;

    out_push    = fire;
    cmd_pop     = fire && done;
    step_nxt    = step_r;
    started_nxt = started_r;
    if (fire) begin
      if (done) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        step_nxt    = sfr_pkg::step_t'(4'(cur_step) + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= sfr_pkg::STEP_HEAD_HI;
      started_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      started_r <= started_nxt;
    end
  end

`ifndef SYNTHESIS
  a_started_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !cmd_empty)
    else $error("serializer mid-word with empty command queue");
`endif

endmodule

@@ src/sensor_command_packet_framer_unit.sv @@
// Top level of the sensor command packet framer.
// Builds command packets for a serial sensor module from payload words. A word
// with first_byte set opens a packet: the unit sends EF 01, the four address
// bytes (most significant first), the flag 01 and the two-byte length
// (payload count, capped at 255, plus 2), then the word's own byte. Later
// words pass their byte through; a word with last_byte set is followed by the
// two checksum bytes (flag + length bytes + payload bytes, modulo 65536),
// high byte first. Words that arrive outside a packet without first_byte are
// dropped with no output. count_error marks every byte caused by a word whose
// last flag disagrees with the declared count; run_end marks the final byte of
// each word and packet_end the low checksum byte. The front checks and sums
// combinationally and writes a command queue (CMD_DEPTH words); the back
// serializes into an output queue (OUT_DEPTH bytes) at one byte per cycle,
// which sets the sustained rate, while it holds a word and the output has
// room; a middle word gives one byte, an opening word ten and a closing word
// two more. Input is taken whenever the command queue has room, also while
// results wait to be popped. Write device_address through cfg_wr_en only
// while the unit is idle; it resets to FFFFFFFF.
module sensor_command_packet_framer_unit #(
  parameter int CMD_DEPTH = sfr_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = sfr_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  sfr_pkg::in_word_t   in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output sfr_pkg::out_word_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  localparam int CMD_W = $bits(sfr_pkg::cmd_t);
  localparam int OUT_W = $bits(sfr_pkg::out_word_t);

  logic [31:0]        device_address_r;
  logic               cmd_full, cmd_empty, cmd_push, cmd_pop;
  sfr_pkg::cmd_t      cmd_wdata, cmd_rdata;
  logic [CMD_W-1:0]   cmd_rbits;
  logic               out_full, out_push;
  sfr_pkg::out_word_t out_wdata;
  logic [OUT_W-1:0]   out_rbits;

  // Hold the address; user must write it only between packets, not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= sfr_pkg::ADDR_RESET;
    end else if (cfg_wr_en) begin
      device_address_r <= cfg_wr_data;
    end
  end

  // Front: classify words, check the count, advance the checksum.
  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata)
  );

  // Decouple the front from the serializer.
  sfr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rbits),
    .empty (cmd_empty)
  );

  assign cmd_rdata = cmd_rbits;

  // Back: expand each command into header, payload and checksum bytes.
  sfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (device_address_r),
    .cmd_empty      (cmd_empty),
    .cmd_data       (cmd_rdata),
    .cmd_pop        (cmd_pop),
    .out_full       (out_full),
    .out_push       (out_push),
    .out_data       (out_wdata)
  );

  // Absorb the header burst ahead of the slow consumer.
  sfr_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_rbits),
    .empty (out_empty)
  );

  assign out_data = out_rbits;

`ifndef SYNTHESIS
  a_pkt_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.packet_end) |-> out_data.run_end)
    else $error("packet end byte not marked as run end");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_push && out_full))
    else $error("serializer wrote a full output queue");
`endif

endmodule

@@ bench/tb_sensor_command_packet_framer_unit.sv @@
// Self-checking testbench for the sensor command packet framer.
module tb_sensor_command_packet_framer_unit;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 420;
  // An opening word passes the back end and both queues; leave ample room.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int REPORT_MAX    = 10;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_push;
  sfr_pkg::in_word_t   in_data;
  logic                in_full;
  logic                out_empty;
  logic                out_pop;
  sfr_pkg::out_word_t  out_data;
  logic                cfg_wr_en;
  logic [31:0]         cfg_wr_data;

  // Expected output bytes, oldest first, and the framer's mirrored state.
  sfr_pkg::out_word_t  frame_bytes_due[$];
  logic [31:0]         addr_model;
  logic [15:0]         sum_acc;
  logic [7:0]          left_cnt;
  logic                pkt_open;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int pop_hold       = 0;
  // While set, neither side starts a new idle stretch.
  bit quiet          = 1'b0;

  always #CLK_HALF clk = ~clk;

  sensor_command_packet_framer_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Payload byte with extra weight on the all-zero and all-one values.
  function automatic logic [7:0] rand_payload();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic sfr_pkg::in_word_t pack_word(logic [7:0] pb, logic f, logic l,
                                                  logic [7:0] c);
    sfr_pkg::in_word_t w;
    w.payload_byte  = pb;
    w.first_byte    = f;
    w.last_byte     = l;
    w.payload_count = c;
    return w;
  endfunction

  // Work out every byte one accepted word causes and queue them; advance the
  // mirrored checksum, remaining count and open flag the way the framer does.
  task automatic frame_word(input sfr_pkg::in_word_t w);
    logic [7:0]         seq [12];
    logic [11:0]        pend_mask;
    logic [8:0]         len;
    logic [7:0]         cnt;
    logic               err;
    sfr_pkg::out_word_t e;
    int                 n;
    n         = 0;
    pend_mask = '0;
    // Drop words that arrive outside a packet without a start mark.
    if (!w.first_byte && !pkt_open) return;
    if (w.first_byte) begin
      // Clamp the declared count; an open packet is abandoned here.
      cnt      = (w.payload_count > sfr_pkg::MAX_PAYLOAD) ? sfr_pkg::MAX_PAYLOAD
                                                          : w.payload_count;
      len      = {1'b0, cnt} + 9'd2;
      pkt_open = 1'b1;
      left_cnt = cnt;
      sum_acc  = 16'(sfr_pkg::CMD_FLAG) + 16'(len[8]) + 16'(len[7:0]);
    end
    // A closing word must use up exactly the last expected byte; any other
    // word is flagged once the count is spent or about to be.
    if (w.last_byte) err = (left_cnt != 8'd1);
    else err = (left_cnt <= 8'd1);
    if (w.first_byte) begin
      seq[0] = sfr_pkg::HEAD_HI;
      seq[1] = sfr_pkg::HEAD_LO;
      seq[2] = addr_model[31:24];
      seq[3] = addr_model[23:16];
      seq[4] = addr_model[15:8];
      seq[5] = addr_model[7:0];
      seq[6] = sfr_pkg::CMD_FLAG;
      seq[7] = {7'd0, len[8]};
      seq[8] = len[7:0];
      n      = 9;
    end
    seq[n]  = w.payload_byte;
    n       = n + 1;
    sum_acc = sum_acc + 16'(w.payload_byte);
    if (left_cnt != 8'd0) left_cnt = left_cnt - 8'd1;
    if (w.last_byte) begin
      seq[n]       = sum_acc[15:8];
      seq[n + 1]   = sum_acc[7:0];
      pend_mask[n + 1] = 1'b1;
      n            = n + 2;
      pkt_open     = 1'b0;
      sum_acc      = '0;
      left_cnt     = '0;
    end
    for (int i = 0; i < n; i++) begin
      e.tx_byte     = seq[i];
      e.run_end     = (i == n - 1);
      e.packet_end  = pend_mask[i];
      e.count_error = err;
      frame_bytes_due.push_back(e);
    end
  endtask

  // Offer one word from a falling edge and hold it until the framer takes it,
  // then maybe idle. Returns at a falling edge with push possibly still high.
  task automatic send_word(input sfr_pkg::in_word_t w);
    int gap;
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    frame_word(w);
    @(negedge clk);
    gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      in_data <= sfr_pkg::in_word_t'(18'($urandom));
      repeat (gap) @(negedge clk);
    end
  endtask

  // Send a packet body of nbytes words; close it with last_byte if asked.
  // The count field only matters on the opening word, so scramble it elsewhere.
  task automatic send_packet(input logic [7:0] cnt, input int nbytes, input bit close);
    for (int i = 0; i < nbytes; i++) begin
      send_word(pack_word(rand_payload(), i == 0, close && (i == nbytes - 1),
                          (i == 0) ? cnt : 8'($urandom)));
    end
  endtask

  // Hold off the sender until every expected byte has been popped.
  task automatic drain();
    in_push <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
  endtask

  // Change the module address only with the framer quiet: drain, let any
  // trailing work settle, then pulse the write for one cycle.
  task automatic write_address(input logic [31:0] a);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    addr_model   = a;
  endtask

  // Result side: pop with random stalls, occasionally long ones.
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_pop <= 1'b0;
      pop_hold = idle_len() - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Compare each popped byte against the oldest expectation.
  always @(posedge clk) begin : check_result
    sfr_pkg::out_word_t due;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_bytes_due.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected byte: tx_byte %02h run_end %b packet_end %b count_error %b",
                   out_data.tx_byte, out_data.run_end, out_data.packet_end,
                   out_data.count_error);
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_data.tx_byte !== due.tx_byte || out_data.run_end !== due.run_end ||
            out_data.packet_end !== due.packet_end ||
            out_data.count_error !== due.count_error) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_MAX)
            $display("exp/act: tx %02h/%02h run %b/%b pend %b/%b err %b/%b",
                     due.tx_byte, out_data.tx_byte, due.run_end, out_data.run_end,
                     due.packet_end, out_data.packet_end,
                     due.count_error, out_data.count_error);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset address goes out on a single-word packet (open and close at once).
  task automatic test_default_address();
    send_word(pack_word(8'h00, 1'b1, 1'b1, 8'd1));
  endtask

  // Count checking and packet structure corner cases.
  task automatic test_count_edges();
    // Drop a stray word while no packet is open.
    send_word(pack_word(8'hFF, 1'b0, 1'b1, 8'hFF));
    // Zero count: length 2 and every byte flagged.
    send_word(pack_word(8'hFF, 1'b1, 1'b0, 8'd0));
    send_word(pack_word(8'h55, 1'b0, 1'b1, 8'hAA));
    // Full count closed far too early; length high byte is set.
    send_word(pack_word(8'h80, 1'b1, 1'b0, 8'd255));
    send_word(pack_word(8'h7F, 1'b0, 1'b1, 8'h00));
    // Overrun: bytes past the count still pass and add to the checksum.
    send_word(pack_word(8'h01, 1'b1, 1'b0, 8'd2));
    send_word(pack_word(8'h02, 1'b0, 1'b0, 8'h01));
    send_word(pack_word(8'h03, 1'b0, 1'b1, 8'h02));
    // Start over inside an open packet: abandon it without a checksum.
    send_word(pack_word(8'h10, 1'b1, 1'b0, 8'd3));
    send_word(pack_word(8'h20, 1'b0, 1'b0, 8'd3));
    send_word(pack_word(8'hAA, 1'b1, 1'b1, 8'd1));
    // Well-formed packet of all-one bytes.
    send_word(pack_word(8'hFF, 1'b1, 1'b0, 8'd3));
    send_word(pack_word(8'hFF, 1'b0, 1'b0, 8'h00));
    send_word(pack_word(8'hFF, 1'b0, 1'b1, 8'hFF));
    // Open and close on one word against a larger declared count.
    send_word(pack_word(8'hC3, 1'b1, 1'b1, 8'd5));
  endtask

  // Sweep the module address through both extremes and mixed patterns.
  task automatic test_address_settings();
    logic [31:0] addr_list [4];
    addr_list[0] = 32'h0000_0000;
    addr_list[1] = 32'hFFFF_FFFF;
    addr_list[2] = 32'h8000_0001;
    addr_list[3] = $urandom;
    for (int i = 0; i < 4; i++) begin
      write_address(addr_list[i]);
      send_packet(8'd2, 2, 1'b1);
    end
  endtask

  // Random traffic: mostly well-formed packets with random content, plus
  // count mismatches, abandoned packets and stray words.
  task automatic test_random_traffic();
    int sent;
    int kind;
    int cnt;
    int nbytes;
    int room;
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      // Move to a fresh address, then later just pause until the output runs dry.
      if (phase == 1) write_address($urandom);
      if (phase == 2) drain();
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 99) < 8) quiet = ~quiet;
        kind = $urandom_range(0, 99);
        // Keep long packets inside what is left of this phase's budget.
        room = (phase + 1) * RANDOM_ITEMS / 3 - sent;
        if (kind < 6) begin
          // Stray word; does not count toward the budget.
          send_word(pack_word(rand_payload(), 1'b0, 1'($urandom), 8'($urandom)));
        end else if (kind < 16) begin
          cnt    = $urandom_range(0, 255);
          nbytes = $urandom_range(1, 8);
          send_packet(8'(cnt), nbytes, 1'b1);
          sent   = sent + nbytes;
        end else if (kind < 22) begin
          cnt    = $urandom_range(2, 10);
          nbytes = $urandom_range(1, cnt - 1);
          send_packet(8'(cnt), nbytes, 1'b0);
          sent   = sent + nbytes;
        end else if (kind < 23 && room >= 64) begin
          cnt    = $urandom_range(64, (room < 255) ? room : 255);
          send_packet(8'(cnt), cnt, 1'b1);
          sent   = sent + cnt;
        end else begin
          cnt    = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 32);
          send_packet(8'(cnt), cnt, 1'b1);
          sent   = sent + cnt;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Wait out the output, check nothing is left, report and stop.
  task automatic finish_run();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (frame_bytes_due.size() != 0) begin
      mismatch_count = mismatch_count + frame_bytes_due.size();
      $display("%0d expected bytes never arrived", frame_bytes_due.size());
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    // Drive every input to a known value, hold reset, release on a falling edge.
    in_push     = 1'b0;
    in_data     = '0;
    out_pop     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    addr_model  = sfr_pkg::ADDR_RESET;
    sum_acc     = '0;
    left_cnt    = '0;
    pkt_open    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_address();
    test_count_edges();
    test_address_settings();
    test_random_traffic();
    finish_run();
  end

endmodule
